### rtl/core/bwg_pkg.sv
// Shared constants and types for the bilinear weight generator.
`timescale 1ns / 1ps

package bwg_pkg;

  // default parameter values
  localparam int FractionBitsDef = 16;
  localparam int AxisSizeBitsDef = 16;

  // fixed field widths
  localparam int PosW     = 32;
  localparam int SubW     = 32;
  localparam int WgtW     = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSizeFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeSecond = 2'd1;

  localparam int SizeReset = 2;

  localparam logic [WgtW-1:0] WgtMax = 32'h7FFF_FFFF;
  localparam logic [WgtW-1:0] WgtMin = 32'h8000_0000;

  // per-stage load enables for the axis front end
  typedef struct packed {
    logic s1;
    logic s2;
  } bwg_adv_t;

endpackage

### rtl/core/bilinear_weight_generator.sv
// Top level: bilinear corner subscripts and weights, five-stage pipeline.
//
//  channel  | direction | handshake            | contents
//  ---------+-----------+----------------------+------------------------------------
//  s_axis   | in        | tvalid/tready        | tdata: position_first, position_second
//  m_axis   | out       | tvalid/tready        | tdata: 4 subscripts, 4 weights; tuser: status
//  cfg      | in        | cfg_valid/cfg_ready  | index 0 size_first_axis, 1 size_second_axis
//
// One beat per cycle sustained while m_axis_tready_i is high; stages are index,
// factors, partial products, product sum, round/saturate. The weight product is
// split into four half-width multiplies per corner, summed one stage later.
// Reset empties the pipeline and sets both axis sizes to 2. A full stage holds
// while the one after it is full and stalled, so bubbles close up on a stall.
`timescale 1ns / 1ps

module bilinear_weight_generator #(
  parameter int FractionBits = bwg_pkg::FractionBitsDef,
  parameter int AxisSizeBits = bwg_pkg::AxisSizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bwg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bwg_pkg::CfgDataW-1:0]  cfg_data_i,
  // input beats
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] position_first, [63:32] position_second
  input  logic [63:0]                   s_axis_tdata_i,
  // output beats
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] subscript_low_low, [63:32] subscript_high_low,
  // [95:64] subscript_low_high, [127:96] subscript_high_high,
  // [159:128] weight_low_low, [191:160] weight_high_low,
  // [223:192] weight_low_high, [255:224] weight_high_high
  output logic [255:0]                  m_axis_tdata_o,
  // [0] status
  output logic                          m_axis_tuser_o
);
  import bwg_pkg::*;

  localparam int FacW  = ((AxisSizeBits + FractionBits > 32) ?
                          AxisSizeBits + FractionBits : 32) + 2;
  localparam int MagW  = FacW - 1;
  localparam int HalfW = (MagW + 1) / 2;
  localparam int PpW   = 2 * HalfW;
  localparam int SumW  = 4 * HalfW + 1;
  localparam int RndW  = SumW - FractionBits;
  localparam int ExtW  = (CfgDataW > AxisSizeBits) ? CfgDataW : AxisSizeBits;

  // config
  logic [AxisSizeBits-1:0] size_first_q, size_second_q;
  logic [ExtW-1:0]         cfg_ext;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = ExtW'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_first_q  <= AxisSizeBits'(SizeReset);
      size_second_q <= AxisSizeBits'(SizeReset);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgSizeFirst) begin
        size_first_q <= cfg_ext[AxisSizeBits-1:0];
      end
      if (cfg_index_i == CfgSizeSecond) begin
        size_second_q <= cfg_ext[AxisSizeBits-1:0];
      end
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  logic e1_q, e2_q, e3_q, e4_q;

  assign en5 = !v5_q || m_axis_tready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) e1_q <= (size_first_q == '0) || (size_second_q == '0);
    if (en2) e2_q <= e1_q;
    if (en3) e3_q <= e2_q;
    if (en4) e4_q <= e3_q;
  end

  // axis front ends: stages 1 and 2
  bwg_adv_t                adv;
  logic [AxisSizeBits-1:0] idx_first, idx_second;
  logic                    fneg_lo, fneg_hi, sneg_lo, sneg_hi;
  logic [MagW-1:0]         fmag_lo, fmag_hi, smag_lo, smag_hi;

  assign adv.s1 = en1;
  assign adv.s2 = en2;

  bwg_axis #(
    .FractionBits (FractionBits),
    .AxisSizeBits (AxisSizeBits)
  ) u_axis_first (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .size_i   (size_first_q),
    .pos_i    (s_axis_tdata_i[31:0]),
    .idx_o    (idx_first),
    .neg_lo_o (fneg_lo),
    .mag_lo_o (fmag_lo),
    .neg_hi_o (fneg_hi),
    .mag_hi_o (fmag_hi)
  );

  bwg_axis #(
    .FractionBits (FractionBits),
    .AxisSizeBits (AxisSizeBits)
  ) u_axis_second (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .size_i   (size_second_q),
    .pos_i    (s_axis_tdata_i[63:32]),
    .idx_o    (idx_second),
    .neg_lo_o (sneg_lo),
    .mag_lo_o (smag_lo),
    .neg_hi_o (sneg_hi),
    .mag_hi_o (smag_hi)
  );

  // stage 2: flat subscript of the low/low corner
  logic [SubW-1:0] base2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      base2_q <= SubW'(idx_first) + SubW'(size_first_q) * SubW'(idx_second);
    end
  end

  // stage 3: corner subscripts and partial products
  logic [SubW-1:0]  inc_first, inc_second;
  logic [SubW-1:0]  sub3_q [4];
  logic [PpW-1:0]   pp_d [4][4];
  logic [PpW-1:0]   pp3_q [4][4];
  logic [3:0]       neg_d, neg3_q;
  logic [MagW-1:0]  fa, sb;
  logic [HalfW-1:0] fa_l, fa_h, sb_l, sb_h;

  assign inc_first  = (size_first_q != AxisSizeBits'(1)) ? SubW'(1) : '0;
  assign inc_second = (size_second_q != AxisSizeBits'(1)) ? SubW'(size_first_q) : '0;

  // corner c: bit 0 picks high on first axis, bit 1 high on second
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      fa       = c[0] ? fmag_hi : fmag_lo;
      sb       = c[1] ? smag_hi : smag_lo;
      neg_d[c] = (c[0] ? fneg_hi : fneg_lo) ^ (c[1] ? sneg_hi : sneg_lo);
      fa_l     = fa[HalfW-1:0];
      fa_h     = HalfW'(fa[MagW-1:HalfW]);
      sb_l     = sb[HalfW-1:0];
      sb_h     = HalfW'(sb[MagW-1:HalfW]);
      pp_d[c][0] = PpW'(fa_l) * PpW'(sb_l);
      pp_d[c][1] = PpW'(fa_l) * PpW'(sb_h);
      pp_d[c][2] = PpW'(fa_h) * PpW'(sb_l);
      pp_d[c][3] = PpW'(fa_h) * PpW'(sb_h);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sub3_q[0] <= base2_q;
      sub3_q[1] <= base2_q + inc_first;
      sub3_q[2] <= base2_q + inc_second;
      sub3_q[3] <= base2_q + inc_first + inc_second;
      neg3_q    <= neg_d;
      pp3_q     <= pp_d;
    end
  end

  // stage 4: product sum plus rounding half
  logic [SumW-1:0] sum_d [4];
  logic [SumW-1:0] sum4_q [4];
  logic [SubW-1:0] sub4_q [4];
  logic [3:0]      neg4_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_d[c] = (SumW'(pp3_q[c][3]) << PpW)
               + ((SumW'(pp3_q[c][1]) + SumW'(pp3_q[c][2])) << HalfW)
               + SumW'(pp3_q[c][0])
               + (SumW'(1) << (FractionBits - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sum4_q <= sum_d;
      sub4_q <= sub3_q;
      neg4_q <= neg3_q;
    end
  end

  // stage 5: scale, sign, saturate
  logic [RndW-1:0] rnd;
  logic            big;
  logic [WgtW-1:0] wgt_d [4];
  logic [WgtW-1:0] wgt5_q [4];
  logic [SubW-1:0] sub5_q [4];
  logic            status5_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rnd = sum4_q[c][SumW-1:FractionBits];
      big = |rnd[RndW-1:WgtW];
      if (e4_q) begin
        wgt_d[c] = '0;
      end else if (!neg4_q[c]) begin
        wgt_d[c] = (big || rnd[WgtW-1]) ? WgtMax : rnd[WgtW-1:0];
      end else if (big || (rnd[WgtW-1] && |rnd[WgtW-2:0])) begin
        wgt_d[c] = WgtMin;
      end else begin
        wgt_d[c] = -rnd[WgtW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      wgt5_q    <= wgt_d;
      status5_q <= e4_q;
      for (int c = 0; c < 4; c++) begin
        sub5_q[c] <= e4_q ? '0 : sub4_q[c];
      end
    end
  end

  assign m_axis_tuser_o = status5_q;
  assign m_axis_tdata_o = {wgt5_q[3], wgt5_q[2], wgt5_q[1], wgt5_q[0],
                           sub5_q[3], sub5_q[2], sub5_q[1], sub5_q[0]};

endmodule

### rtl/core/bwg_axis.sv
// One axis: low grid index (stage 1) and signed corner factors (stage 2).
`timescale 1ns / 1ps

module bwg_axis #(
  parameter int FractionBits = bwg_pkg::FractionBitsDef,
  parameter int AxisSizeBits = bwg_pkg::AxisSizeBitsDef,
  localparam int FacW = ((AxisSizeBits + FractionBits > 32) ?
                         AxisSizeBits + FractionBits : 32) + 2,
  localparam int MagW = FacW - 1
) (
  input  logic                    clk_i,
  input  bwg_pkg::bwg_adv_t       adv_i,
  input  logic [AxisSizeBits-1:0] size_i,
  input  logic signed [31:0]      pos_i,
  output logic [AxisSizeBits-1:0] idx_o,
  output logic                    neg_lo_o,
  output logic [MagW-1:0]         mag_lo_o,
  output logic                    neg_hi_o,
  output logic [MagW-1:0]         mag_hi_o
);
  import bwg_pkg::*;

  logic                    skip;
  logic [31:0]             quo, szm1, szm2;
  logic [AxisSizeBits-1:0] idx_d, idx_q;
  logic signed [31:0]      pos_q;
  logic                    skip_q;

  logic [FacW-1:0] l_ext, p_ext, fac_lo, fac_hi, nfac_lo, nfac_hi;
  logic            neg_lo_d, neg_hi_d;
  logic [MagW-1:0] mag_lo_d, mag_hi_d;

  assign skip = (size_i == AxisSizeBits'(1));

  // truncated index; negative positions clamp to zero, large ones to size - 2
  always_comb begin
    quo  = 32'(pos_i[PosW-1:FractionBits]);
    szm1 = 32'(size_i) - 32'd1;
    szm2 = 32'(size_i) - 32'd2;
    if (skip || pos_i[PosW-1]) begin
      idx_d = '0;
    end else if (quo >= szm1) begin
      idx_d = szm2[AxisSizeBits-1:0];
    end else begin
      idx_d = quo[AxisSizeBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      idx_q  <= idx_d;
      pos_q  <= pos_i;
      skip_q <= skip;
    end
  end

  assign idx_o = idx_q;

  // skipped axis weighs one half on both corners
  always_comb begin
    l_ext = FacW'(idx_q);
    p_ext = FacW'(pos_q);
    if (skip_q) begin
      fac_lo = FacW'(1) << (FractionBits - 1);
      fac_hi = FacW'(1) << (FractionBits - 1);
    end else begin
      fac_lo = ((l_ext + FacW'(1)) << FractionBits) - p_ext;
      fac_hi = p_ext - (l_ext << FractionBits);
    end
    nfac_lo  = -fac_lo;
    nfac_hi  = -fac_hi;
    neg_lo_d = fac_lo[FacW-1];
    neg_hi_d = fac_hi[FacW-1];
    mag_lo_d = neg_lo_d ? nfac_lo[MagW-1:0] : fac_lo[MagW-1:0];
    mag_hi_d = neg_hi_d ? nfac_hi[MagW-1:0] : fac_hi[MagW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      neg_lo_o <= neg_lo_d;
      mag_lo_o <= mag_lo_d;
      neg_hi_o <= neg_hi_d;
      mag_hi_o <= mag_hi_d;
    end
  end

endmodule
